[hdl/min_tracking_stack_macros.svh]
// ----------------------------------------------------------------------------
// Min tracking stack assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

[hdl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// Min tracking stack package
// Shared types, codes and defaults for the min tracking stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int COUNT_OUT_W     = 7;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     is_empty;
        logic [1:0]               status;
    } t_rsp;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] run_min;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

[hdl/mts_cell.sv]
// ----------------------------------------------------------------------------
// Min tracking stack cell
// One stack slot that loads from the slot above on push and below on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_cell (
    input  logic            i_clk,
    input  mts_pkg::t_shift i_shift,
    input  mts_pkg::t_entry i_above,
    input  mts_pkg::t_entry i_below,
    output mts_pkg::t_entry o_entry
);

    mts_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift.push) begin
            r_entry <= i_above;
        end else if (i_shift.pop) begin
            r_entry <= i_below;
        end
    end

    assign o_entry = r_entry;

endmodule

[hdl/mts_ctrl.sv]
// ----------------------------------------------------------------------------
// Min tracking stack control
// Fill count, status, running minimum of a push and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_ctrl #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  mts_pkg::t_req   i_req,
    input  mts_pkg::t_entry i_top,
    output mts_pkg::t_shift o_shift,
    output mts_pkg::t_entry o_new_entry,
    output logic            o_strobe,
    output mts_pkg::t_rsp   o_rsp
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_strobe;
    logic          n_strobe;
    logic          full;
    logic          empty_now;
    logic [CW+mts_pkg::COUNT_OUT_W-1:0] count_ext;

    assign full      = (r_count == CW'(STACK_DEPTH));
    assign empty_now = (r_count == '0);

    always_comb begin
        n_count       = r_count;
        n_status      = r_status;
        n_strobe      = i_accept;
        o_shift.push  = 1'b0;
        o_shift.pop   = 1'b0;
        if (i_accept) begin
            n_status = mts_pkg::ST_OK;
            if (i_req.cmd == mts_pkg::CMD_PUSH) begin
                if (full) begin
                    n_status = mts_pkg::ST_FULL;
                end else begin
                    o_shift.push = 1'b1;
                    n_count      = r_count + CW'(1);
                end
            end else begin
                if (empty_now) begin
                    n_status = mts_pkg::ST_EMPTY;
                end else begin
                    o_shift.pop = 1'b1;
                    n_count     = r_count - CW'(1);
                end
            end
        end
    end

    always_comb begin
        o_new_entry.value   = i_req.push_value;
        o_new_entry.run_min = i_req.push_value;
        if (!empty_now && (i_top.run_min < i_req.push_value)) begin
            o_new_entry.run_min = i_top.run_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= mts_pkg::ST_OK;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_status <= n_status;
            r_strobe <= n_strobe;
        end
    end

    assign count_ext = {{mts_pkg::COUNT_OUT_W{1'b0}}, r_count};

    always_comb begin
        o_rsp.top_value   = empty_now ? '0 : i_top.value;
        o_rsp.min_value   = empty_now ? '0 : i_top.run_min;
        o_rsp.entry_count = count_ext[mts_pkg::COUNT_OUT_W-1:0];
        o_rsp.is_empty    = empty_now;
        o_rsp.status      = r_status;
    end

    assign o_strobe = r_strobe;

endmodule

[hdl/min_tracking_stack.sv]
// ----------------------------------------------------------------------------
// Min tracking stack
// LIFO of signed 32-bit values that reports the running minimum.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle; busy is held low. The
// result of a request appears on the result port with o_strobe for one cycle,
// one cycle after the request is taken, and must be captured then. The stack
// is a row of STACK_DEPTH cells that all shift one place down on a push and
// one place up on a pop, so the top entry and its running minimum always sit
// in the first cell and every operation finishes in that single cycle. No
// clearing pass is needed after reset: only entries below the fill count are
// ever shown.
`timescale 1ns / 1ps

module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mts_pkg::t_req i_req,
    output logic          o_strobe,
    output mts_pkg::t_rsp o_rsp
);

    mts_pkg::t_entry cell_q [STACK_DEPTH];
    mts_pkg::t_entry new_entry;
    mts_pkg::t_shift shift;
    logic            accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    mts_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_req),
        .i_top      (cell_q[0]),
        .o_shift    (shift),
        .o_new_entry(new_entry),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp)
    );

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        mts_pkg::t_entry above;
        mts_pkg::t_entry below;

        if (g == 0) begin : g_first
            assign above = new_entry;
        end else begin : g_mid
            assign above = cell_q[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign below = cell_q[g];
        end else begin : g_inner
            assign below = cell_q[g+1];
        end

        mts_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(shift),
            .i_above(above),
            .i_below(below),
            .o_entry(cell_q[g])
        );
    end

endmodule

[hdl/mts_checker.sv]
// ----------------------------------------------------------------------------
// Min tracking stack checker
// Port-level assertions on request timing and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_tracking_stack_macros.svh"

module mts_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input mts_pkg::t_rsp o_rsp
);

    logic req_taken;
    logic empty_shown;
    logic zeros_shown;
    logic underflow_shown;
    logic entry_shown;
    logic min_in_order;

    assign req_taken       = start && !busy;
    assign empty_shown     = o_strobe && o_rsp.is_empty;
    assign zeros_shown     = (o_rsp.top_value == '0) && (o_rsp.min_value == '0);
    assign underflow_shown = o_strobe && (o_rsp.status == mts_pkg::ST_EMPTY);
    assign entry_shown     = o_strobe && !o_rsp.is_empty;
    assign min_in_order    = (o_rsp.min_value <= o_rsp.top_value);

    `MTS_ASSERT_NEXT(a_result_follows_request, i_clk, i_rst_n, req_taken, o_strobe)
    `MTS_ASSERT_NEXT(a_no_result_without_request, i_clk, i_rst_n, !req_taken, !o_strobe)
    `MTS_ASSERT_NOW(a_empty_reads_zero, i_clk, i_rst_n, empty_shown, zeros_shown)
    `MTS_ASSERT_NOW(a_underflow_is_empty, i_clk, i_rst_n, underflow_shown, o_rsp.is_empty)
    `MTS_ASSERT_NOW(a_min_not_above_top, i_clk, i_rst_n, entry_shown, min_in_order)

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_rsp   (o_rsp)
);

[test/min_tracking_stack_checker.sv]
// ----------------------------------------------------------------------------
// Min tracking stack checker
// Watches the request and result channels of the min tracking stack, keeps
// its own copy of the stack with the running minimum of every entry, and
// compares each result with the oldest predicted report, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_checker #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  mts_pkg::t_req i_req,
    input  logic          i_strobe,
    input  mts_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);

    import mts_pkg::*;

    logic signed [DATA_W-1:0] shadow_value [STACK_DEPTH];
    logic signed [DATA_W-1:0] shadow_run_min [STACK_DEPTH];
    int                       shadow_fill;
    t_rsp                     pending_reports [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        shadow_fill  = 0;
    end

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    function automatic t_rsp apply_stack_op(input t_req req);
        t_rsp                     report;
        logic signed [DATA_W-1:0] new_min;
        logic [1:0]               code;
        report = '0;
        code   = ST_OK;
        if (req.cmd == CMD_PUSH) begin
            if (shadow_fill >= STACK_DEPTH) begin
                code = ST_FULL;
            end else begin
                new_min = $signed(req.push_value);
                if (shadow_fill > 0 && $signed(shadow_run_min[shadow_fill-1]) < new_min) begin
                    new_min = shadow_run_min[shadow_fill-1];
                end
                shadow_value[shadow_fill]   = req.push_value;
                shadow_run_min[shadow_fill] = new_min;
                shadow_fill++;
            end
        end else if (shadow_fill == 0) begin
            code = ST_EMPTY;
        end else begin
            shadow_fill--;
        end
        if (shadow_fill > 0) begin
            report.top_value = shadow_value[shadow_fill-1];
            report.min_value = shadow_run_min[shadow_fill-1];
        end
        report.entry_count = shadow_fill[COUNT_OUT_W-1:0];
        report.is_empty    = (shadow_fill == 0);
        report.status      = code;
        return report;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            pending_reports.delete();
            o_pending <= 0;
        end else begin
            if (i_strobe) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t ns: result with no request pending, expected none, actual 0x%h",
                             $time, i_rsp);
                    o_fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("top_value", want.top_value, i_rsp.top_value);
                    compare_field("min_value", want.min_value, i_rsp.min_value);
                    compare_field("entry_count", DATA_W'(want.entry_count),
                                  DATA_W'(i_rsp.entry_count));
                    compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(i_rsp.is_empty));
                    compare_field("status", DATA_W'(want.status), DATA_W'(i_rsp.status));
                end
            end
            if (i_start && !i_busy) begin
                pending_reports.insert(pending_reports.size(), apply_stack_op(i_req));
            end
            o_pending <= pending_reports.size();
        end
    end

endmodule

[test/tb_min_tracking_stack.sv]
// ----------------------------------------------------------------------------
// Min tracking stack testbench
// Drives a short directed sequence and then phases of push-heavy, pop-heavy
// and mixed random requests with random gaps, so the stack fills, overflows,
// drains and underflows repeatedly. A checker beside the block predicts and
// compares every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_min_tracking_stack;

    import mts_pkg::*;

    localparam int RANDOM_REQUESTS = 800;
    localparam int CYCLE_LIMIT     = 200000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;
    int   cycle_count;

    min_tracking_stack uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    min_tracking_stack_checker #(
        .STACK_DEPTH (STACK_DEPTH_DEF)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk       = 1'b0;
        cycle_count = 0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return $signed($urandom_range(0, 16)) - 8;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic cmd, input logic signed [DATA_W-1:0] value,
                                input int gap);
        start <= 1'b1;
        i_req <= '{cmd: cmd, push_value: value};
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        int   sent;
        int   phase;
        int   phase_len;
        int   push_pct;
        bit   steady;
        logic cmd;
        start   <= 1'b0;
        i_req   <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_POP, 32'sh7fff_ffff, 0);
        send_request(CMD_PUSH, 32'sh7fff_ffff, 0);
        send_request(CMD_PUSH, 32'sh8000_0000, 1);
        send_request(CMD_PUSH, 32'sd5, 0);
        send_request(CMD_PUSH, 32'sh8000_0000, 0);
        send_request(CMD_PUSH, -32'sd1, 2);
        send_request(CMD_PUSH, 32'sd0, 0);
        send_request(CMD_POP, 32'sh8000_0000, 0);
        send_request(CMD_POP, -32'sd1, 0);
        send_request(CMD_POP, 32'sd0, 0);
        send_request(CMD_POP, 32'sd0, 0);
        send_request(CMD_POP, 32'sd0, 0);
        send_request(CMD_POP, -32'sd1, 0);
        send_request(CMD_PUSH, -32'sd1, 0);
        send_request(CMD_PUSH, -32'sd2, 0);
        send_request(CMD_PUSH, -32'sd2, 0);
        send_request(CMD_POP, 32'sd0, 0);
        send_request(CMD_POP, 32'sd0, 0);
        send_request(CMD_POP, 32'sd0, 0);
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_REQUESTS) begin
            case (phase % 3)
                0: push_pct = 90;
                1: push_pct = 10;
                default: push_pct = 50;
            endcase
            phase_len = $urandom_range(90, 140);
            steady    = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
                cmd = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
                send_request(cmd, pick_value(), steady ? 0 : pick_gap());
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                wait_drained();
            end
            phase++;
        end
        wait_drained();

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
